// File: design/spf_sieve_divisor_sum_assert.svh
// Assertion macros shared by the divisor-sum block; they sample on clk_i and idle in reset.
`ifndef SPF_SIEVE_DIVISOR_SUM_ASSERT_SVH
`define SPF_SIEVE_DIVISOR_SUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/spf_pkg.sv
// Package with widths, codes and controller/datapath types of the divisor-sum block.
`timescale 1ns / 1ps

package spf_pkg;

  localparam int QUERY_W        = 16;
  localparam int SUM_W          = 20;
  localparam int TABLE_SIZE_DEF = 65536;
  localparam int DIV_CNT_W      = $clog2(QUERY_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUERY_W - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_OUT_RD,
    ST_OUT_CHK,
    ST_INNER,
    ST_IDLE,
    ST_Q_RD,
    ST_Q_SPF,
    ST_Q_DIV,
    ST_Q_MUL,
    ST_Q_ACC,
    ST_Q_CLOSE,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_OUTER_RD,
    OP_OUTER_CHK,
    OP_INNER,
    OP_Q_RD,
    OP_Q_SPF,
    OP_Q_MUL,
    OP_Q_ACC,
    OP_Q_CLOSE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   div_start;
    logic   in_ready;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic q_direct;
    logic clear_last;
    logic outer_last;
    logic prime_inner;
    logic inner_last;
    logic div_done;
    logic x_one;
    logic same_prime;
    logic out_full;
  } dp_status_t;

endpackage

// File: design/spf_if.sv
// Handshake interfaces for the query and result channels.
`timescale 1ns / 1ps

interface spf_query_if import spf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [QUERY_W-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink (input valid, input query_value, output ready);
endinterface

interface spf_result_if import spf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] divisor_sum;
  logic [SUM_W-1:0] proper_divisor_sum;

  modport source (output valid, output divisor_sum, output proper_divisor_sum, input ready);
  modport sink (input valid, input divisor_sum, input proper_divisor_sum, output ready);
endinterface

// File: design/spf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module spf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/spf_div.sv
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`include "spf_sieve_divisor_sum_assert.svh"

module spf_div import spf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [QUERY_W-1:0] dividend_i,
  input  logic [QUERY_W-1:0] divisor_i,
  output logic [QUERY_W-1:0] quotient_o,
  output logic               done_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [QUERY_W-1:0]   quo_q;
  logic [QUERY_W-1:0]   rem_q;
  logic [QUERY_W-1:0]   dvs_q;
  logic [QUERY_W:0]     trial;
  logic [QUERY_W:0]     diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[QUERY_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[QUERY_W-1:0] : trial[QUERY_W-1:0];
      quo_q <= {quo_q[QUERY_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = busy_q && (cnt_q == DIV_LAST);

  `SPF_ASSERT_IMPL(a_div_no_restart, start_i, !busy_q, "divider restarted while busy")

endmodule

// File: design/spf_dp.sv
// Datapath: factor table, sieve counters, divider, geometric-sum arithmetic and result register.
`timescale 1ns / 1ps
`include "spf_sieve_divisor_sum_assert.svh"

module spf_dp import spf_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  spf_query_if.sink    query_i,
  spf_result_if.source result_o
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CW    = (IDX_W + 1 > QUERY_W) ? IDX_W + 1 : QUERY_W;
  localparam logic [IDX_W:0]  N_IDX    = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W:0]  LAST_IDX = (IDX_W + 1)'(TABLE_SIZE - 1);
  localparam logic [CW-1:0]   N_CW     = CW'(TABLE_SIZE);

  logic [IDX_W:0]     i_q;
  logic [IDX_W:0]     j_q;
  logic [IDX_W+1:0]   sq_q;
  logic [QUERY_W-1:0] q_q;
  logic [QUERY_W-1:0] x_q;
  logic [QUERY_W-1:0] p_q;
  logic [QUERY_W-1:0] term_q;
  logic [SUM_W-1:0]   geo_q;
  logic [SUM_W-1:0]   sigma_q;
  logic               res_valid_q;
  logic [SUM_W-1:0]   div_sum_q;
  logic [SUM_W-1:0]   prop_sum_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [IDX_W-1:0]   rdata;

  logic               rd_zero;
  logic               sq_in;
  logic [IDX_W:0]     j_step;
  logic               advance;
  logic [CW-1:0]      x_cw;
  logic [CW-1:0]      rd_cw;
  logic [CW-1:0]      quo_cw;
  logic [CW-1:0]      query_cw;
  logic [QUERY_W-1:0] p_sel;
  logic [QUERY_W-1:0] quo;
  logic               div_done;
  logic               q_oob;
  logic               q_small;
  logic               accept;
  logic [2*QUERY_W-1:0] prod_tp;
  logic [2*SUM_W-1:0]   prod_sg;

  assign rd_zero  = (rdata == '0);
  assign sq_in    = (sq_q < {1'b0, N_IDX});
  assign j_step   = j_q + i_q;
  assign x_cw     = CW'(x_q);
  assign rd_cw    = CW'(rdata);
  assign quo_cw   = CW'(quo);
  assign query_cw = CW'(query_i.query_value);
  assign p_sel    = (rd_cw < CW'(2)) ? x_q : rd_cw[QUERY_W-1:0];
  assign q_oob    = (query_cw >= N_CW);
  assign q_small  = (query_i.query_value <= QUERY_W'(1));
  assign accept   = query_i.valid && cmd_i.in_ready;
  assign prod_tp  = term_q * p_q;
  assign prod_sg  = sigma_q * geo_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j_q[IDX_W-1:0];
    ram_wdata = i_q[IDX_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = x_cw[IDX_W-1:0];
    advance   = 1'b0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      OP_OUTER_RD: begin
        ram_re    = 1'b1;
        ram_raddr = i_q[IDX_W-1:0];
      end
      OP_OUTER_CHK: begin
        ram_we    = rd_zero;
        ram_waddr = i_q[IDX_W-1:0];
        ram_re    = rd_zero && sq_in;
        ram_raddr = sq_q[IDX_W-1:0];
        advance   = !(rd_zero && sq_in);
      end
      OP_INNER: begin
        ram_we    = rd_zero;
        ram_re    = (j_step < N_IDX);
        ram_raddr = j_step[IDX_W-1:0];
        advance   = (j_step >= N_IDX);
      end
      OP_Q_RD: begin
        ram_re = 1'b1;
      end
      OP_Q_MUL: begin
        ram_re    = 1'b1;
        ram_raddr = quo_cw[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  spf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  spf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (x_q),
    .divisor_i  (p_sel),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= (IDX_W + 1)'(2);
      j_q         <= '0;
      sq_q        <= (IDX_W + 2)'(4);
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        j_q <= j_q + 1'b1;
      end else if (cmd_i.op == OP_OUTER_CHK && rd_zero && sq_in) begin
        j_q <= sq_q[IDX_W:0];
      end else if (cmd_i.op == OP_INNER) begin
        j_q <= j_step;
      end
      if (advance) begin
        i_q <= i_q + 1'b1;
        if (sq_in) begin
          sq_q <= sq_q + {i_q, 1'b1};
        end
      end
      if (cmd_i.out_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= query_i.query_value;
      q_q     <= q_oob ? '0 : (q_small ? QUERY_W'(1) : query_i.query_value);
      sigma_q <= q_oob ? '0 : SUM_W'(1);
    end
    unique case (cmd_i.op)
      OP_Q_SPF: begin
        p_q    <= p_sel;
        term_q <= QUERY_W'(1);
        geo_q  <= SUM_W'(1);
      end
      OP_Q_MUL: begin
        x_q    <= quo;
        term_q <= prod_tp[QUERY_W-1:0];
      end
      OP_Q_ACC: begin
        geo_q <= geo_q + SUM_W'(term_q);
      end
      OP_Q_CLOSE: begin
        sigma_q <= prod_sg[SUM_W-1:0];
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      div_sum_q  <= sigma_q;
      prop_sum_q <= sigma_q - SUM_W'(q_q);
    end
  end

  assign query_i.ready               = cmd_i.in_ready;
  assign result_o.valid              = res_valid_q;
  assign result_o.divisor_sum        = div_sum_q;
  assign result_o.proper_divisor_sum = prop_sum_q;

  assign status_o.in_valid    = query_i.valid;
  assign status_o.q_direct    = q_oob || q_small;
  assign status_o.clear_last  = (j_q == LAST_IDX);
  assign status_o.outer_last  = (i_q == LAST_IDX);
  assign status_o.prime_inner = rd_zero && sq_in;
  assign status_o.inner_last  = (j_step >= N_IDX);
  assign status_o.div_done    = div_done;
  assign status_o.x_one       = (x_q == QUERY_W'(1));
  assign status_o.same_prime  = (p_sel == p_q);
  assign status_o.out_full    = res_valid_q && !result_o.ready;

  `SPF_ASSERT_IMPL(a_no_overwrite, cmd_i.out_load, !(res_valid_q && !result_o.ready),
                   "result word overwritten before it was taken")
  `SPF_ASSERT_IMPL(a_write_in_fill, ram_we,
                   cmd_i.op == OP_CLEAR || cmd_i.op == OP_OUTER_CHK || cmd_i.op == OP_INNER,
                   "factor table written outside the fill")
  `SPF_ASSERT_IMPL(a_factor_valid, cmd_i.op == OP_Q_SPF, rd_cw >= CW'(2),
                   "factor table entry below two for a composite value")
  `SPF_ASSERT_NEXT(a_quotient_nonzero, cmd_i.op == OP_Q_MUL, x_q != '0,
                   "division by a factor gave a zero quotient")

endmodule

// File: design/spf_ctrl.sv
// Controller state machine sequencing the table fill and the factoring of each query.
`timescale 1ns / 1ps

module spf_ctrl import spf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_CHK;
      end
      ST_OUT_CHK: begin
        if (status_i.prime_inner) begin
          state_d = ST_INNER;
        end else begin
          state_d = status_i.outer_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      ST_INNER: begin
        if (status_i.inner_last) state_d = status_i.outer_last ? ST_IDLE : ST_OUT_RD;
      end
      ST_IDLE: begin
        if (status_i.in_valid) state_d = status_i.q_direct ? ST_FINISH : ST_Q_RD;
      end
      ST_Q_RD: begin
        state_d = ST_Q_SPF;
      end
      ST_Q_SPF: begin
        state_d = ST_Q_DIV;
      end
      ST_Q_DIV: begin
        if (status_i.div_done) state_d = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        state_d = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        if (!status_i.x_one && status_i.same_prime) begin
          state_d = ST_Q_DIV;
        end else begin
          state_d = ST_Q_CLOSE;
        end
      end
      ST_Q_CLOSE: begin
        state_d = status_i.x_one ? ST_FINISH : ST_Q_SPF;
      end
      ST_FINISH: begin
        if (!status_i.out_full) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o.op        = OP_NOP;
    cmd_o.div_start = 1'b0;
    cmd_o.in_ready  = 1'b0;
    cmd_o.out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR:   cmd_o.op = OP_CLEAR;
      ST_OUT_RD:  cmd_o.op = OP_OUTER_RD;
      ST_OUT_CHK: cmd_o.op = OP_OUTER_CHK;
      ST_INNER:   cmd_o.op = OP_INNER;
      ST_IDLE:    cmd_o.in_ready = 1'b1;
      ST_Q_RD:    cmd_o.op = OP_Q_RD;
      ST_Q_SPF: begin
        cmd_o.op        = OP_Q_SPF;
        cmd_o.div_start = 1'b1;
      end
      ST_Q_DIV:   cmd_o.op = OP_NOP;
      ST_Q_MUL:   cmd_o.op = OP_Q_MUL;
      ST_Q_ACC: begin
        cmd_o.op        = OP_Q_ACC;
        cmd_o.div_start = !status_i.x_one && status_i.same_prime;
      end
      ST_Q_CLOSE: cmd_o.op = OP_Q_CLOSE;
      ST_FINISH:  cmd_o.out_load = !status_i.out_full;
      default: begin
      end
    endcase
  end

endmodule

// File: design/spf_sieve_divisor_sum.sv
// Top level of the divisor-sum block built on a smallest-prime-factor table.
//
// A query word on query_i carries one 16-bit value; each query gives one
// result word on result_o with the divisor sum and the proper divisor sum.
// Values 0 and 1 give a divisor sum of 1 and a proper sum of 0, and values at
// or beyond TABLE_SIZE give zero in both fields.
// After reset the table is cleared in one pass over all TABLE_SIZE entries
// and then filled by a sieve; no query is accepted until the fill is done.
// One query is factored at a time. Each prime factor is taken out by the
// one-bit-per-cycle divider, plus one table read per factor. Out-of-range
// values, 0 and 1 skip the factoring and go straight to the result
// register. The next query is accepted in the cycle after the result is
// loaded at the earliest.
// The result register holds a finished word while the next query is taken;
// if the receiver stalls, the following result waits until the register is
// free and no further query is accepted until then.

`timescale 1ns / 1ps

module spf_sieve_divisor_sum import spf_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spf_query_if.sink    query_i,
  spf_result_if.source result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  spf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  spf_dp #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .query_i  (query_i),
    .result_o (result_o)
  );

endmodule
